[rtl/pid_controller_clamped_unit_defines.svh]
// Assertion macros used by the PID controller checker.
`ifndef PID_CONTROLLER_CLAMPED_UNIT_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_DEFINES_SVH

// Same-cycle implication, off while rst is high.
`define PIDC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, off while rst is high.
`define PIDC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/pidc_pkg.sv]
// Shared types, constants and the microcode table of the PID controller.
package pidc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ILIM_UNITS    = 100000;
  localparam int OLIM_UNITS    = 10000;

  localparam int CFG_W     = 47;
  localparam int CFG_IDX_W = 3;
  localparam int ILIM_W    = 47;
  localparam int OLIM_W    = 31;
  localparam int STEP_W    = 5;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = 6;

  localparam logic [63:0] PROD_CAP = 64'd1 << 48;
  localparam logic [79:0] TERM_CAP = 80'd1 << 58;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_ILIM   = 3'd3,
    REG_OLIM   = 3'd4,
    REG_PERIOD = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] error_in;
    logic [31:0]        timestamp;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               updated;
  } result_t;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_LOAD   = 4'd1,
    OP_DT     = 4'd2,
    OP_SETOP  = 4'd3,
    OP_MUL    = 4'd4,
    OP_PSAT   = 4'd5,
    OP_INTEG  = 4'd6,
    OP_ACCLO  = 4'd7,
    OP_ACCHI  = 4'd8,
    OP_TERM   = 4'd9,
    OP_ADD    = 4'd10,
    OP_OCLAMP = 4'd11,
    OP_EMIT   = 4'd12
  } op_t;

  typedef enum logic [1:0] {A_ERR, A_KP, A_KI, A_KD} asel_t;
  typedef enum logic [2:0] {B_DT, B_ERR, B_ILO, B_IHI, B_DER} bsel_t;
  typedef enum logic [1:0] {W_NONE, W_NO_SAMPLE, W_DIV_BUSY, W_OUT_BUSY} wait_t;
  typedef enum logic [1:0] {J_NONE, J_ALWAYS, J_DT_LT} jmp_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE = 5'd0;
  localparam step_t S_HOLD = 5'd26;

  typedef struct packed {
    op_t   op;
    asel_t a_sel;
    bsel_t b_sel;
    logic  div_start;
    logic  upd;
    wait_t wait_c;
    jmp_t  jmp_c;
    step_t target;
  } ucw_t;

  typedef struct packed {
    logic dt_lt;
    logic div_busy;
  } dp_sts_t;

  typedef struct packed {
    logic no_sample;
    logic out_busy;
    logic dt_lt;
    logic div_busy;
  } seq_sts_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  function automatic ucw_t uw(input op_t op, input asel_t a, input bsel_t b,
                              input logic ds, input logic upd, input wait_t w,
                              input jmp_t j, input step_t t);
    ucw_t r;
    r.op        = op;
    r.a_sel     = a;
    r.b_sel     = b;
    r.div_start = ds;
    r.upd       = upd;
    r.wait_c    = w;
    r.jmp_c     = j;
    r.target    = t;
    return r;
  endfunction

  function automatic ucw_t plain(input op_t op);
    return uw(op, A_ERR, B_DT, 1'b0, 1'b0, W_NONE, J_NONE, S_IDLE);
  endfunction

  function automatic ucw_t setop(input asel_t a, input bsel_t b);
    return uw(OP_SETOP, a, b, 1'b0, 1'b0, W_NONE, J_NONE, S_IDLE);
  endfunction

  // Microcode: one control word per step.
  function automatic ucw_t ucode(input step_t s);
    ucw_t r;
    case (s)
      5'd0:  r = uw(OP_LOAD, A_ERR, B_DT, 1'b0, 1'b0, W_NO_SAMPLE, J_NONE, S_IDLE);
      5'd1:  r = plain(OP_DT);
      // err*dt operands; divider starts on |err - prev_err| / dt
      5'd2:  r = uw(OP_SETOP, A_ERR, B_DT, 1'b1, 1'b0, W_NONE, J_DT_LT, S_HOLD);
      5'd3:  r = plain(OP_MUL);
      5'd4:  r = plain(OP_PSAT);
      5'd5:  r = plain(OP_INTEG);
      5'd6:  r = setop(A_KP, B_ERR);
      5'd7:  r = plain(OP_MUL);
      5'd8:  r = plain(OP_ACCLO);
      5'd9:  r = plain(OP_TERM);
      5'd10: r = plain(OP_ADD);
      5'd11: r = setop(A_KI, B_ILO);
      5'd12: r = plain(OP_MUL);
      5'd13: r = plain(OP_ACCLO);
      5'd14: r = setop(A_KI, B_IHI);
      5'd15: r = plain(OP_MUL);
      5'd16: r = plain(OP_ACCHI);
      5'd17: r = plain(OP_TERM);
      5'd18: r = plain(OP_ADD);
      5'd19: r = uw(OP_SETOP, A_KD, B_DER, 1'b0, 1'b0, W_DIV_BUSY, J_NONE, S_IDLE);
      5'd20: r = plain(OP_MUL);
      5'd21: r = plain(OP_ACCLO);
      5'd22: r = plain(OP_TERM);
      5'd23: r = plain(OP_ADD);
      5'd24: r = plain(OP_OCLAMP);
      5'd25: r = uw(OP_EMIT, A_ERR, B_DT, 1'b0, 1'b1, W_OUT_BUSY, J_ALWAYS, S_IDLE);
      5'd26: r = uw(OP_EMIT, A_ERR, B_DT, 1'b0, 1'b0, W_OUT_BUSY, J_ALWAYS, S_IDLE);
      default: r = uw(OP_NOP, A_ERR, B_DT, 1'b0, 1'b0, W_NONE, J_ALWAYS, S_IDLE);
    endcase
    return r;
  endfunction

endpackage

[rtl/pid_controller_clamped_unit.sv]
// Updating item: the bit-serial divider for the derivative sets the time from input
// transfer to result; a new item is taken only once the last one's result is emitted.
// Held item (elapsed time below sample_period): the previous drive is emitted, not updated.
// A finished result waits in the output register; the next item is taken meanwhile.
// rst (synchronous): clears controller state and result valid, gains and period
// to zero, limits to their defaults.
module pid_controller_clamped_unit import pidc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [63:0] ILIM_FULL = 64'(ILIM_UNITS) << FRAC_BITS;
  localparam logic [ILIM_W-1:0] ILIM_RST = ILIM_FULL[ILIM_W-1:0];
  localparam logic [63:0] OLIM_FULL = 64'(OLIM_UNITS) << FRAC_BITS;
  localparam logic [63:0] OLIM_MAX = (64'd1 << OLIM_W) - 64'd1;
  localparam logic [OLIM_W-1:0] OLIM_RST =
    (OLIM_FULL > OLIM_MAX) ? OLIM_MAX[OLIM_W-1:0] : OLIM_FULL[OLIM_W-1:0];

  logic [31:0]        kp;
  logic [31:0]        ki;
  logic [31:0]        kd;
  logic [ILIM_W-1:0]  integral_limit;
  logic [OLIM_W-1:0]  output_limit;
  logic [31:0]        sample_period;

  ucw_t               ctl;
  logic               go;
  dp_sts_t            dp_sts;
  seq_sts_t           seq_sts;
  logic signed [31:0] held_drive;
  logic               emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp             <= '0;
      ki             <= '0;
      kd             <= '0;
      integral_limit <= ILIM_RST;
      output_limit   <= OLIM_RST;
      sample_period  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:     kp             <= cfg_data[31:0];
        REG_KI:     ki             <= cfg_data[31:0];
        REG_KD:     kd             <= cfg_data[31:0];
        REG_ILIM:   integral_limit <= cfg_data[ILIM_W-1:0];
        REG_OLIM:   output_limit   <= cfg_data[OLIM_W-1:0];
        REG_PERIOD: sample_period  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign sample_stall = rst || (ctl.op != OP_LOAD);

  assign seq_sts.no_sample = !sample_valid;
  assign seq_sts.out_busy  = result_valid && result_stall;
  assign seq_sts.dt_lt     = dp_sts.dt_lt;
  assign seq_sts.div_busy  = dp_sts.div_busy;

  pidc_seq u_seq (
    .clk (clk),
    .rst (rst),
    .sts (seq_sts),
    .ctl (ctl),
    .go  (go)
  );

  pidc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .go             (go),
    .smp            (sample),
    .kp             (kp),
    .ki             (ki),
    .kd             (kd),
    .integral_limit (integral_limit),
    .output_limit   (output_limit),
    .sample_period  (sample_period),
    .sts            (dp_sts),
    .held_drive     (held_drive)
  );

  // emit only runs when the output register is free or being drained
  assign emit = go && (ctl.op == OP_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.drive   <= held_drive;
      result.updated <= ctl.upd;
    end
  end

endmodule

[rtl/pidc_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle, unsigned.
module pidc_div import pidc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dq;
  logic [DIV_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_W:0]       sh;
  logic [DIV_W:0]       trial;
  logic                 fits;

  assign sh    = {rem, dq[DIV_W-1]};
  assign fits  = (sh >= {1'b0, den});
  assign trial = sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // dq shifts the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dq  <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= fits ? trial[DIV_W-1:0] : sh[DIV_W-1:0];
      dq  <= {dq[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.quo  = dq;

endmodule

[rtl/pidc_dp.sv]
// Datapath of the PID controller: shared 32x32 multiplier, adders, clamps, state.
module pidc_dp import pidc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ucw_t               ctl,
  input  logic               go,
  input  sample_t            smp,
  input  logic [31:0]        kp,
  input  logic [31:0]        ki,
  input  logic [31:0]        kd,
  input  logic [ILIM_W-1:0]  integral_limit,
  input  logic [OLIM_W-1:0]  output_limit,
  input  logic [31:0]        sample_period,
  output dp_sts_t            sts,
  output logic signed [31:0] held_drive
);

  logic signed [31:0] err_q;
  logic [31:0]        now_q;
  logic [31:0]        dt_q;
  logic [31:0]        prev_ts;
  logic signed [31:0] prev_error;
  logic signed [47:0] integ;
  logic [31:0]        opa;
  logic [31:0]        opb;
  logic               psign;
  logic               dneg;
  logic [63:0]        mul_q;
  logic [79:0]        pacc;
  logic [58:0]        tmag;
  logic signed [49:0] pterm;
  logic signed [60:0] sum;

  logic [31:0]        a_mag;
  logic               a_neg;
  logic [31:0]        b_mag;
  logic               b_neg;
  logic [47:0]        imag;
  logic [31:0]        der_mag;
  logic signed [32:0] diff;
  logic [32:0]        diff_abs;
  logic [63:0]        mul_full;
  logic [48:0]        psat;
  logic signed [50:0] isum;
  logic signed [50:0] ilim_s;
  logic signed [50:0] ilim_neg;
  logic signed [47:0] integ_new;
  logic [79:0]        pshift;
  logic signed [60:0] tsx;
  logic signed [60:0] olim_s;
  logic signed [60:0] olim_neg;
  logic signed [31:0] drive_new;
  logic               exec;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  assign exec = go;

  assign diff     = {err_q[31], err_q} - {prev_error[31], prev_error};
  assign diff_abs = diff[32] ? (~diff + 33'd1) : diff;
  assign imag     = integ[47] ? (~integ + 48'd1) : integ;
  // zero elapsed time gives a zero derivative
  assign der_mag  = (dt_q == 32'd0) ? 32'd0 : div_rsp.quo;

  always_comb begin
    case (ctl.a_sel)
      A_ERR:   begin a_mag = mag32(err_q); a_neg = err_q[31]; end
      A_KP:    begin a_mag = mag32(kp);    a_neg = kp[31];    end
      A_KI:    begin a_mag = mag32(ki);    a_neg = ki[31];    end
      A_KD:    begin a_mag = mag32(kd);    a_neg = kd[31];    end
      default: begin a_mag = '0;           a_neg = 1'b0;      end
    endcase
    case (ctl.b_sel)
      B_DT:    begin b_mag = dt_q;                b_neg = 1'b0;      end
      B_ERR:   begin b_mag = mag32(err_q);        b_neg = err_q[31]; end
      B_ILO:   begin b_mag = imag[31:0];          b_neg = integ[47]; end
      B_IHI:   begin b_mag = {16'd0, imag[47:32]}; b_neg = integ[47]; end
      B_DER:   begin b_mag = der_mag;             b_neg = dneg;      end
      default: begin b_mag = '0;                  b_neg = 1'b0;      end
    endcase
  end

  assign mul_full = opa * opb;

  always_comb begin
    psat      = (mul_q > PROD_CAP) ? PROD_CAP[48:0] : mul_q[48:0];
    isum      = 51'(integ) + 51'(pterm);
    ilim_s    = $signed({4'd0, integral_limit});
    ilim_neg  = -ilim_s;
    if (isum > ilim_s) begin
      integ_new = ilim_s[47:0];
    end else if (isum < ilim_neg) begin
      integ_new = ilim_neg[47:0];
    end else begin
      integ_new = isum[47:0];
    end
    pshift    = pacc >> FRAC_BITS;
    tsx       = $signed({2'd0, tmag});
    olim_s    = $signed({30'd0, output_limit});
    olim_neg  = -olim_s;
    if (sum > olim_s) begin
      drive_new = olim_s[31:0];
    end else if (sum < olim_neg) begin
      drive_new = olim_neg[31:0];
    end else begin
      drive_new = sum[31:0];
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      integ      <= '0;
      prev_ts    <= '0;
      held_drive <= '0;
    end else if (exec) begin
      case (ctl.op)
        OP_INTEG: integ <= integ_new;
        OP_OCLAMP: begin
          held_drive <= drive_new;
          prev_ts    <= now_q;
          prev_error <= err_q;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (exec) begin
      if (ctl.div_start) begin
        dneg <= diff[32];
      end
      case (ctl.op)
        OP_LOAD: begin
          err_q <= smp.error_in;
          now_q <= smp.timestamp;
          sum   <= '0;
        end
        OP_DT: dt_q <= now_q - prev_ts;
        OP_SETOP: begin
          opa   <= a_mag;
          opb   <= b_mag;
          psign <= a_neg ^ b_neg;
        end
        OP_MUL:   mul_q <= mul_full;
        OP_PSAT:  pterm <= psign ? -$signed({1'b0, psat}) : $signed({1'b0, psat});
        OP_ACCLO: pacc <= {16'd0, mul_q};
        OP_ACCHI: pacc[79:32] <= pacc[79:32] + mul_q[47:0];
        OP_TERM:  tmag <= (pshift > TERM_CAP) ? TERM_CAP[58:0] : pshift[58:0];
        OP_ADD:   sum <= psign ? (sum - tsx) : (sum + tsx);
        default: ;
      endcase
    end
  end

  assign div_req.start = exec && ctl.div_start;
  assign div_req.num   = diff_abs[31:0];
  assign div_req.den   = dt_q;

  pidc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign sts.dt_lt    = (dt_q < sample_period);
  assign sts.div_busy = div_rsp.busy;

endmodule

[rtl/pidc_seq.sv]
// Microcode sequencer: step counter, control word lookup, waits and jumps.
module pidc_seq import pidc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  seq_sts_t sts,
  output ucw_t     ctl,
  output logic     go
);

  step_t step;
  step_t step_next;
  logic  waiting;
  logic  jump;

  assign ctl = ucode(step);

  always_comb begin
    case (ctl.wait_c)
      W_NONE:      waiting = 1'b0;
      W_NO_SAMPLE: waiting = sts.no_sample;
      W_DIV_BUSY:  waiting = sts.div_busy;
      W_OUT_BUSY:  waiting = sts.out_busy;
      default:     waiting = 1'b0;
    endcase
    case (ctl.jmp_c)
      J_NONE:   jump = 1'b0;
      J_ALWAYS: jump = 1'b1;
      J_DT_LT:  jump = sts.dt_lt;
      default:  jump = 1'b0;
    endcase
    // a waiting step holds and does nothing
    if (waiting) begin
      step_next = step;
    end else if (jump) begin
      step_next = ctl.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  assign go = !waiting;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[rtl/pidc_checker.sv]
// Port-level checker for the PID controller, bound to the top level.
`include "pid_controller_clamped_unit_defines.svh"

module pidc_checker import pidc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // only one sample in work at a time
  `PIDC_ASSERT_NXT(a_one_in_work, clk, rst, sample_valid && !sample_stall, sample_stall)
  // a new result shows up only when the sequencer is back at its input step
  `PIDC_ASSERT_IMP(a_result_at_idle, clk, rst, $rose(result_valid), !sample_stall)
  `PIDC_ASSERT_NXT(a_reset_clears, clk, 1'b0, rst, !result_valid)
  `PIDC_ASSERT_NXT(a_result_holds, clk, rst, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind pid_controller_clamped_unit pidc_checker u_pidc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
